[rtl/core/rap_pkg.sv]
package rap_pkg;

    localparam int HDR_LEN = 12;
    localparam logic [7:0] RTP_BYTE0 = 8'h80;
    localparam logic [7:0] RTP_BYTE1 = 8'h61;

    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_PAYLOAD_BYTES     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_PER_PACKET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_SEQUENCE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_TIMESTAMP = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_ID         = 3'd4;

    localparam logic [10:0] RESET_PAYLOAD_BYTES     = 11'd288;
    localparam logic [7:0]  RESET_FRAMES_PER_PACKET = 8'd48;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        pkt_start;
        logic        pkt_end;
        logic [15:0] seq;
        logic [31:0] ts;
    } t_item;

    function automatic logic [7:0] hdr_byte(
        input logic [3:0]  idx,
        input logic [15:0] seq,
        input logic [31:0] ts,
        input logic [31:0] ssrc
    );
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = RTP_BYTE0;
            4'd1:    b = RTP_BYTE1;
            4'd2:    b = seq[15:8];
            4'd3:    b = seq[7:0];
            4'd4:    b = ts[31:24];
            4'd5:    b = ts[23:16];
            4'd6:    b = ts[15:8];
            4'd7:    b = ts[7:0];
            4'd8:    b = ssrc[31:24];
            4'd9:    b = ssrc[23:16];
            4'd10:   b = ssrc[15:8];
            4'd11:   b = ssrc[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/rap_front.sv]
module rap_front #(
    parameter int MAX_PAYLOAD_BYTES = 1460
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rap_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_payload_byte,
    output logic                        o_push,
    output rap_pkg::t_item              o_item,
    input  logic                        i_full,
    output logic [31:0]                 o_source_id
);
    import rap_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int CW = (PW > 11 ? PW : 11) + 1;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_PAYLOAD_BYTES);

    logic [10:0]   r_payload_bytes;
    logic [7:0]    r_frames;
    logic [15:0]   r_init_seq;
    logic [31:0]   r_init_ts;
    logic [31:0]   r_source_id;
    logic [PW-1:0] r_pos;
    logic [15:0]   r_seq;
    logic [31:0]   r_ts;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 accept;
    logic [CW-1:0]        len_min;
    logic [CW-1:0]        len_eff;
    logic [CW-1:0]        pos_next;
    logic                 ends;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        prdata = 32'h0;
        unique case (reg_idx)
            REG_PAYLOAD_BYTES:     prdata = {21'h0, r_payload_bytes};
            REG_FRAMES_PER_PACKET: prdata = {24'h0, r_frames};
            REG_INITIAL_SEQUENCE:  prdata = {16'h0, r_init_seq};
            REG_INITIAL_TIMESTAMP: prdata = r_init_ts;
            REG_SOURCE_ID:         prdata = r_source_id;
            default:               prdata = 32'h0;
        endcase
    end

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid & !i_full;

    always_comb begin
        len_min  = (r_payload_bytes == 11'd0) ? CW'(1) : CW'(r_payload_bytes);
        len_eff  = (len_min > MAX_LEN) ? MAX_LEN : len_min;
        pos_next = CW'(r_pos) + CW'(1);
        ends     = pos_next >= len_eff;
    end

    assign o_push              = accept;
    assign o_item.payload_byte = i_payload_byte;
    assign o_item.pkt_start    = (r_pos == '0);
    assign o_item.pkt_end      = ends;
    assign o_item.seq          = r_seq;
    assign o_item.ts           = r_ts;
    assign o_source_id         = r_source_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_bytes <= RESET_PAYLOAD_BYTES;
            r_frames        <= RESET_FRAMES_PER_PACKET;
            r_init_seq      <= 16'h0;
            r_init_ts       <= 32'h0;
            r_source_id     <= 32'h0;
            r_pos           <= '0;
            r_seq           <= 16'h0;
            r_ts            <= 32'h0;
        end else begin
            if (accept) begin
                if (ends) begin
                    r_pos <= '0;
                    r_seq <= r_seq + 16'd1;
                    r_ts  <= r_ts + {24'h0, r_frames};
                end else begin
                    r_pos <= pos_next[PW-1:0];
                end
            end
            if (wr_en) begin
                unique case (reg_idx)
                    REG_PAYLOAD_BYTES:     r_payload_bytes <= pwdata[10:0];
                    REG_FRAMES_PER_PACKET: r_frames <= pwdata[7:0];
                    REG_INITIAL_SEQUENCE: begin
                        r_init_seq <= pwdata[15:0];
                        r_seq      <= pwdata[15:0];
                    end
                    REG_INITIAL_TIMESTAMP: begin
                        r_init_ts <= pwdata;
                        r_ts      <= pwdata;
                    end
                    REG_SOURCE_ID:         r_source_id <= pwdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/core/rap_fifo.sv]
module rap_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rap_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rap_pkg::t_item o_item
);
    import rap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push & !o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/rap_back.sv]
module rap_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rap_pkg::t_item i_item,
    output logic           o_pop,
    input  logic [31:0]    i_source_id,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_is_header,
    output logic           o_packet_start,
    output logic           o_packet_end,
    output logic           o_run_last
);
    import rap_pkg::*;

    logic [3:0] r_hdr_idx;
    logic [3:0] n_hdr_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_is_header;
    logic       r_packet_start;
    logic       r_packet_end;
    logic       r_run_last;

    logic slot_free;
    logic in_header;
    logic load;

    assign slot_free = !r_out_valid || i_out_ready;
    assign load      = slot_free && i_valid;
    assign in_header = i_item.pkt_start && (r_hdr_idx != 4'(HDR_LEN));
    assign o_pop     = load && !in_header;

    always_comb begin
        n_hdr_idx = r_hdr_idx;
        if (load) begin
            n_hdr_idx = in_header ? r_hdr_idx + 4'd1 : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
            if (slot_free) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (in_header) begin
                r_out_byte     <= hdr_byte(r_hdr_idx, i_item.seq, i_item.ts, i_source_id);
                r_is_header    <= 1'b1;
                r_packet_start <= (r_hdr_idx == 4'd0);
                r_packet_end   <= 1'b0;
                r_run_last     <= 1'b0;
            end else begin
                r_out_byte     <= i_item.payload_byte;
                r_is_header    <= 1'b0;
                r_packet_start <= 1'b0;
                r_packet_end   <= i_item.pkt_end;
                r_run_last     <= 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_is_header    = r_is_header;
    assign o_packet_start = r_packet_start;
    assign o_packet_end   = r_packet_end;
    assign o_run_last     = r_run_last;

endmodule

[rtl/core/rtp_audio_packetizer.sv]
// Frames a byte stream of audio payload into RTP packets with the 12-byte fixed header
// (version 2, payload type 97, sequence number, timestamp, source id). Each accepted byte
// leaves as one output transaction, and the first byte of a packet is preceded by 12 header
// transactions, so the block moves one byte per cycle while the output is ready. The front
// stage accepts one byte per cycle while the queue is not full, decides packet start and
// end and records the header values into a small queue; the back stage expands queued
// entries into header and payload bytes through a registered output, so the rate is set by
// the single output byte per cycle while the downstream is ready. Registers sit at byte
// addresses 0, 4, 8, 12 and 16; writing the initial sequence or timestamp also loads the
// running value, and configuration should change only while no transaction is in flight.
module rtp_audio_packetizer #(
    parameter int MAX_PAYLOAD_BYTES = 1460,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rap_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_payload_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_is_header,
    output logic                        o_packet_start,
    output logic                        o_packet_end,
    output logic                        o_run_last
);
    import rap_pkg::*;

    logic        push;
    t_item       push_item;
    logic        full;
    logic        pop;
    logic        head_valid;
    t_item       head_item;
    logic [31:0] source_id;

    assign pready = 1'b1;

    rap_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .o_push         (push),
        .o_item         (push_item),
        .i_full         (full),
        .o_source_id    (source_id)
    );

    rap_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    rap_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (head_valid),
        .i_item         (head_item),
        .o_pop          (pop),
        .i_source_id    (source_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_header    (o_is_header),
        .o_packet_start (o_packet_start),
        .o_packet_end   (o_packet_end),
        .o_run_last     (o_run_last)
    );

endmodule
